// File: hw/rtl/ccrc_pkg.sv
// ----------------------------------------------------------------------------
// ccrc_pkg: shared types and constants of the chunk cutter
// Holds the transaction structs of the byte and chunk channels and the fixed
// CRC-32 and configuration constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ccrc_pkg;

  localparam int unsigned FIELD_BITS = 48;
  localparam int unsigned MIN_BITS   = 21;
  localparam int unsigned CRC_BITS   = 32;

  localparam logic [MIN_BITS-1:0] MIN_RESET = MIN_BITS'(2048);
  localparam logic [CRC_BITS-1:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [CRC_BITS-1:0] CRC_INIT  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       cut_candidate;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] chunk_offset;
    logic [FIELD_BITS-1:0] chunk_length;
    logic [CRC_BITS-1:0]   chunk_crc;
    logic                  last_of_run;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/chunk_cutter_with_crc32.sv
// ----------------------------------------------------------------------------
// chunk_cutter_with_crc32: content-defined chunk cutter with per-chunk CRC-32
// Cuts a byte stream into chunks at flagged bytes once the open chunk holds
// min_chunk_size bytes, and reports offset, length and CRC-32 of each chunk.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle while in_stall is low. The cut
// decision, the CRC-32 byte update and the counter advance happen
// combinationally between the state registers and a two-entry result
// buffer. A byte that both closes a chunk and ends the file yields two
// results, delivered one after the other; the input stalls while the
// second one drains from the buffer. The user must write min_chunk_size
// through the cfg port only while the block is idle; the block does not
// enforce this. A value of zero acts as one.
`default_nettype none

module chunk_cutter_with_crc32 #(
  parameter int unsigned OFFSET_BITS = 48
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire ccrc_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output ccrc_pkg::out_item_t              out_data,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [ccrc_pkg::MIN_BITS-1:0]     cfg_data
);

  import ccrc_pkg::*;

  localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;

  function automatic logic [CRC_BITS-1:0] crc_byte(input logic [CRC_BITS-1:0] crc_in,
                                                   input logic [7:0] b);
    logic [CRC_BITS-1:0] c;
    c = crc_in ^ {{(CRC_BITS-8){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {CRC_BITS{c[0]}});
    end
    return c;
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_field(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+FIELD_BITS-1:0] wide;
    wide = {{FIELD_BITS{1'b0}}, v};
    return wide[FIELD_BITS-1:0];
  endfunction

  logic [MIN_BITS-1:0]    min_size_r;
  logic [OFFSET_BITS-1:0] position_r, position_nxt;
  logic [OFFSET_BITS-1:0] chunk_start_r, chunk_start_nxt;
  logic [CRC_BITS-1:0]    running_crc_r, running_crc_nxt;

  out_item_t              res_r [2];
  out_item_t              res_nxt [2];
  logic [1:0]             res_v_r, res_v_nxt;

  logic                   in_fire, out_fire;
  logic [OFFSET_BITS-1:0] min_eff, held, start1, pos_inc, eof_len;
  logic [CRC_BITS-1:0]    crc1, crc2;
  logic                   cut;

  assign cfg_ready = 1'b1;

  assign out_valid = res_v_r[0] | res_v_r[1];
  assign out_data  = res_v_r[0] ? res_r[0] : res_r[1];
  assign out_fire  = out_valid & ~out_stall;

  // accept when the buffer is empty or its last entry leaves this cycle
  assign in_stall = ~((res_v_r == 2'b00) ||
                      (out_fire && (res_v_r == 2'b01 || res_v_r == 2'b10)));
  assign in_fire  = in_valid & ~in_stall;

  always_comb begin
    min_eff = (min_size_r == '0) ? OFFSET_BITS'(1) : OFFSET_BITS'(min_size_r);
    held    = position_r - chunk_start_r;
    cut     = in_data.cut_candidate && (held >= min_eff);
    start1  = cut ? position_r : chunk_start_r;
    crc1    = cut ? CRC_INIT : running_crc_r;
    crc2    = crc_byte(crc1, in_data.data_byte);
    pos_inc = (position_r != CNT_MAX) ? position_r + OFFSET_BITS'(1) : position_r;
    eof_len = pos_inc - start1;
    if (pos_inc == CNT_MAX && eof_len != CNT_MAX) begin
      eof_len = eof_len + OFFSET_BITS'(1);
    end
    if (eof_len == '0) begin
      eof_len = OFFSET_BITS'(1);
    end

    position_nxt    = position_r;
    chunk_start_nxt = chunk_start_r;
    running_crc_nxt = running_crc_r;
    res_nxt[0]      = res_r[0];
    res_nxt[1]      = res_r[1];
    res_v_nxt       = res_v_r;

    if (out_fire) begin
      if (res_v_r[0]) begin
        res_v_nxt[0] = 1'b0;
      end else begin
        res_v_nxt[1] = 1'b0;
      end
    end

    if (in_fire) begin
      if (in_data.end_of_file) begin
        position_nxt    = '0;
        chunk_start_nxt = '0;
        running_crc_nxt = CRC_INIT;
      end else begin
        position_nxt    = pos_inc;
        chunk_start_nxt = start1;
        running_crc_nxt = crc2;
      end

      res_nxt[1].chunk_offset = to_field(start1);
      res_nxt[1].chunk_length = to_field(eof_len);
      res_nxt[1].chunk_crc    = ~crc2;
      res_nxt[1].last_of_run  = 1'b1;

      if (cut) begin
        res_nxt[0].chunk_offset = to_field(chunk_start_r);
        res_nxt[0].chunk_length = to_field(held);
        res_nxt[0].chunk_crc    = ~running_crc_r;
        res_nxt[0].last_of_run  = ~in_data.end_of_file;
      end else begin
        res_nxt[0] = res_nxt[1];
      end

      res_v_nxt[0] = cut | in_data.end_of_file;
      res_v_nxt[1] = cut & in_data.end_of_file;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r    <= MIN_RESET;
      position_r    <= '0;
      chunk_start_r <= '0;
      running_crc_r <= CRC_INIT;
      res_v_r       <= 2'b00;
    end else begin
      if (cfg_valid && cfg_ready) begin
        min_size_r <= cfg_data;
      end
      position_r    <= position_nxt;
      chunk_start_r <= chunk_start_nxt;
      running_crc_r <= running_crc_nxt;
      res_v_r       <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r[0] <= res_nxt[0];
    res_r[1] <= res_nxt[1];
  end

  a_not_last_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_of_run) |-> (res_v_r == 2'b11))
    else $error("non-final result without a pending second result");

  a_eof_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.end_of_file) |=> out_valid)
    else $error("end of file transaction produced no result");

  a_eof_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.end_of_file) |=>
      (position_r == '0 && chunk_start_r == '0 && running_crc_r == CRC_INIT))
    else $error("state not cleared after end of file");

  a_start_behind_pos: assert property (@(posedge clk) disable iff (!rst_n)
    chunk_start_r <= position_r)
    else $error("chunk start ahead of position");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for chunk_cutter_with_crc32
// Streams files byte by byte with random cut-candidate flags under several
// minimum chunk sizes, predicts every chunk's offset, length and CRC-32, and
// checks each chunk transaction in order under random idling and back pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  import ccrc_pkg::*;

  localparam int unsigned ITEM_TARGET = 850;
  localparam int unsigned IDLE_WAIT   = 8;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [FIELD_BITS-1:0] POS_MAX = '1;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [MIN_BITS-1:0] cfg_data  = '0;

  logic [MIN_BITS-1:0]   min_bytes  = MIN_RESET;
  logic [FIELD_BITS-1:0] file_pos   = '0;
  logic [FIELD_BITS-1:0] chunk_base = '0;
  logic [CRC_BITS-1:0]   crc_reg    = CRC_INIT;
  out_item_t             pending_chunks[$];

  int unsigned fail_count  = 0;
  int unsigned bytes_sent  = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_asked  = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  logic        steady      = 1'b0;

  chunk_cutter_with_crc32 #(
    .OFFSET_BITS(FIELD_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CRC_BITS-1:0] crc32_byte(input logic [CRC_BITS-1:0] crc,
                                                     input logic [7:0] b);
    logic [CRC_BITS-1:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic predict_chunks(input in_item_t item);
    logic [FIELD_BITS-1:0] eff_min;
    logic [FIELD_BITS-1:0] held;
    logic [FIELD_BITS-1:0] len;
    out_item_t             res[2];
    int                    n;
    n = 0;
    eff_min = (min_bytes == '0) ? FIELD_BITS'(1) : FIELD_BITS'(min_bytes);
    held = file_pos - chunk_base;
    if (item.cut_candidate && held >= eff_min) begin
      res[n] = '{chunk_offset: chunk_base, chunk_length: held,
                 chunk_crc: ~crc_reg, last_of_run: 1'b0};
      n++;
      chunk_base = file_pos;
      crc_reg = CRC_INIT;
    end
    crc_reg = crc32_byte(crc_reg, item.data_byte);
    if (file_pos != POS_MAX) file_pos = file_pos + FIELD_BITS'(1);
    if (item.end_of_file) begin
      len = file_pos - chunk_base;
      if (file_pos == POS_MAX && len != POS_MAX) len = len + FIELD_BITS'(1);
      if (len == '0) len = FIELD_BITS'(1);
      res[n] = '{chunk_offset: chunk_base, chunk_length: len,
                 chunk_crc: ~crc_reg, last_of_run: 1'b0};
      n++;
      file_pos = '0;
      chunk_base = '0;
      crc_reg = CRC_INIT;
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) pending_chunks.push_back(res[i]);
  endtask

  task automatic check_chunk(input out_item_t got);
    out_item_t want;
    if (pending_chunks.size() == 0) begin
      $error("unexpected chunk: offset %0d length %0d crc %h",
             got.chunk_offset, got.chunk_length, got.chunk_crc);
      fail_count++;
    end else begin
      want = pending_chunks.pop_front();
      if (got.chunk_offset !== want.chunk_offset) begin
        $error("chunk_offset: expected %0d, got %0d", want.chunk_offset, got.chunk_offset);
        fail_count++;
      end
      if (got.chunk_length !== want.chunk_length) begin
        $error("chunk_length: expected %0d, got %0d", want.chunk_length, got.chunk_length);
        fail_count++;
      end
      if (got.chunk_crc !== want.chunk_crc) begin
        $error("chunk_crc: expected %h, got %h", want.chunk_crc, got.chunk_crc);
        fail_count++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_chunks(in_data);
      if (out_valid && !out_stall) check_chunk(out_data);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // hold off for a long stretch on request, else stall at random
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic cand, input logic eof);
    in_item_t    item;
    int unsigned gap;
    item.data_byte = b;
    item.cut_candidate = cand;
    item.end_of_file = eof;
    gap = (steady || $urandom_range(0, 1)) ? 0 : pick_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_min(input logic [MIN_BITS-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    min_bytes = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_file(input int unsigned len, input int unsigned cand_pct);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom), $urandom_range(0, 99) < cand_pct, i == len - 1);
    end
  endtask

  task automatic test_reset_min();
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hA5, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b1, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b1);
  endtask

  task automatic test_min_zero();
    write_min('0);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h7F, 1'b1, 1'b0);
    send_byte(8'hFE, 1'b1, 1'b1);
  endtask

  task automatic test_single_byte_files();
    write_min(MIN_BITS'(1));
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b1, 1'b1);
  endtask

  task automatic test_min_three();
    write_min(MIN_BITS'(3));
    for (int i = 0; i < 8; i++) send_byte(8'($urandom), 1'b1, i == 7);
  endtask

  task automatic test_back_pressure();
    write_min(MIN_BITS'(1));
    steady = 1'b1;
    hold_asked++;
    for (int i = 0; i < 40; i++) send_byte(8'($urandom), 1'b1, i == 39);
    steady = 1'b0;
  endtask

  task automatic test_random_files();
    logic [MIN_BITS-1:0] min_choice;
    int unsigned         pct;
    int unsigned         len;
    while (bytes_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       min_choice = '0;
        1:       min_choice = MIN_BITS'(1);
        2:       min_choice = MIN_BITS'(2);
        3, 4, 5: min_choice = MIN_BITS'($urandom_range(3, 40));
        6, 7:    min_choice = MIN_BITS'($urandom_range(41, 200));
        8:       min_choice = MIN_BITS'(1048576);
        default: min_choice = '1;
      endcase
      write_min(min_choice);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 4))
          0:       pct = 0;
          1:       pct = 5;
          2:       pct = 25;
          3:       pct = 60;
          default: pct = 100;
        endcase
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
        steady = ($urandom_range(0, 4) == 0);
        send_file(len, pct);
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_min();
    test_min_zero();
    test_single_byte_files();
    test_min_three();
    test_back_pressure();
    test_random_files();
    wait_idle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
